### hdl/sspq_pkg.sv
// ----------------------------------------------------------------------------
// sspq_pkg
// shared types, widths and codes for the sorted size priority queue
// ----------------------------------------------------------------------------
package sspq_pkg;

  localparam int DEPTH = 16;
  localparam int KEY_W = 32;
  localparam int TAG_W = 16;
  localparam int CMD_W = 3;
  localparam int CNT_W = $clog2(DEPTH + 1);

  // input word layout, lowest bit first
  localparam int IN_CMD_LO = 0;
  localparam int IN_KEY_LO = IN_CMD_LO + CMD_W;
  localparam int IN_TAG_LO = IN_KEY_LO + KEY_W;
  localparam int IN_USED   = IN_TAG_LO + TAG_W;
  localparam int IN_W      = ((IN_USED + 7) / 8) * 8;

  // output word layout, lowest bit first
  localparam int OUT_USED = 1 + KEY_W + TAG_W + CNT_W + 1;
  localparam int OUT_W    = ((OUT_USED + 7) / 8) * 8;

  typedef enum logic [CMD_W-1:0] {
    CMD_INSERT     = 3'd0,
    CMD_POP_FIRST  = 3'd1,
    CMD_POP_SECOND = 3'd2,
    CMD_COUNT      = 3'd3,
    CMD_CLEAR      = 3'd4
  } cmd_t;

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } state_t;

  typedef struct packed {
    logic capture;
    logic execute;
  } dp_ctrl_t;

endpackage

### hdl/sspq_datapath.sv
// ----------------------------------------------------------------------------
// sspq_datapath
// command register, sorted slot shift register and result register
// ----------------------------------------------------------------------------
module sspq_datapath (
  input  logic                        clk,
  input  logic                        rst,
  input  sspq_pkg::dp_ctrl_t          ctrl,
  input  logic [sspq_pkg::IN_W-1:0]   s_data,
  output logic [sspq_pkg::OUT_W-1:0]  m_data
);
  import sspq_pkg::*;

  cmd_t             in_cmd;
  logic [KEY_W-1:0] in_key;
  logic [TAG_W-1:0] in_tag;

  logic [KEY_W-1:0] slot_key [DEPTH];
  logic [TAG_W-1:0] slot_tag [DEPTH];
  logic [CNT_W-1:0] held;
  logic [CNT_W-1:0] held_next;

  logic             res_found;
  logic [KEY_W-1:0] res_key;
  logic [TAG_W-1:0] res_tag;
  logic [CNT_W-1:0] res_count;
  logic             res_ovf;

  logic [DEPTH-1:0] at_or_after;   // slot lies at or behind the insert point
  logic             full;
  logic             do_ins;
  logic             do_pop1;
  logic             do_pop2;
  logic             do_ovf;
  logic             pop_pos;       // 0 largest, 1 second largest

  always_ff @(posedge clk) begin
    if (ctrl.capture) begin
      in_cmd <= cmd_t'(s_data[IN_CMD_LO +: CMD_W]);
      in_key <= s_data[IN_KEY_LO +: KEY_W];
      in_tag <= s_data[IN_TAG_LO +: TAG_W];
    end
  end

  // every slot compares against the new key at once
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      if (CNT_W'(i) < held) begin
        at_or_after[i] = slot_key[i] < in_key;
      end else begin
        at_or_after[i] = 1'b1;
      end
    end
  end

  always_comb begin
    full    = (held == CNT_W'(DEPTH));
    do_ins  = ctrl.execute && (in_cmd == CMD_INSERT) && !full;
    do_ovf  = ctrl.execute && (in_cmd == CMD_INSERT) && full;
    do_pop1 = ctrl.execute && (in_cmd == CMD_POP_FIRST) && (held != '0);
    do_pop2 = ctrl.execute && (in_cmd == CMD_POP_SECOND) && (held > CNT_W'(1));
    pop_pos = do_pop2;
    held_next = held;
    if (ctrl.execute) begin
      if (in_cmd == CMD_CLEAR) begin
        held_next = '0;
      end else if (do_ins) begin
        held_next = held + CNT_W'(1);
      end else if (do_pop1 || do_pop2) begin
        held_next = held - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= '0;
    end else begin
      held <= held_next;
    end
  end

  // slot update: open a gap for an insert, close one after a pop
  always_ff @(posedge clk) begin
    for (int i = 0; i < DEPTH; i++) begin
      if (do_ins && at_or_after[i]) begin
        if (i == 0) begin
          slot_key[i] <= in_key;
          slot_tag[i] <= in_tag;
        end else if (!at_or_after[(i == 0) ? 0 : i - 1]) begin
          slot_key[i] <= in_key;
          slot_tag[i] <= in_tag;
        end else begin
          slot_key[i] <= slot_key[(i == 0) ? 0 : i - 1];
          slot_tag[i] <= slot_tag[(i == 0) ? 0 : i - 1];
        end
      end else if ((do_pop1 || do_pop2) && (i < DEPTH - 1)
                   && ((i != 0) || !pop_pos)) begin
        slot_key[i] <= slot_key[(i < DEPTH - 1) ? i + 1 : i];
        slot_tag[i] <= slot_tag[(i < DEPTH - 1) ? i + 1 : i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.execute) begin
      res_found <= do_pop1 || do_pop2;
      res_ovf   <= do_ovf;
      res_count <= held_next;
      if (do_pop1 || do_pop2) begin
        res_key <= pop_pos ? slot_key[1] : slot_key[0];
        res_tag <= pop_pos ? slot_tag[1] : slot_tag[0];
      end else begin
        res_key <= '0;
        res_tag <= '0;
      end
    end
  end

  assign m_data = {{(OUT_W - OUT_USED){1'b0}}, res_ovf, res_count, res_tag, res_key,
                   res_found};

endmodule

### hdl/sspq_ctrl.sv
// ----------------------------------------------------------------------------
// sspq_ctrl
// sequencer for capture and execute, and the result valid flag
// ----------------------------------------------------------------------------
module sspq_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               s_tvalid,
  output logic               s_tready,
  output logic               m_tvalid,
  input  logic               m_tready,
  output sspq_pkg::dp_ctrl_t ctrl
);
  import sspq_pkg::*;

  state_t state;
  state_t state_next;
  logic   out_valid;
  logic   out_valid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    state_next     = state;
    s_tready       = 1'b0;
    ctrl.capture   = 1'b0;
    ctrl.execute   = 1'b0;
    out_valid_next = out_valid && !m_tready;
    case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          ctrl.capture = 1'b1;
          state_next   = ST_EXEC;
        end
      end
      ST_EXEC: begin
        // result register must be free or emptying this cycle
        if (!out_valid || m_tready) begin
          ctrl.execute   = 1'b1;
          out_valid_next = 1'b1;
          state_next     = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  assign m_tvalid = out_valid;

endmodule

### hdl/sorted_size_priority_queue.sv
// ----------------------------------------------------------------------------
// sorted_size_priority_queue
// sorted queue of (size key, tag) entries, largest key first, with insert,
// pop largest, pop second largest, count and clear commands
// ----------------------------------------------------------------------------
//
//  channel | direction | word contents (lowest bit first)
//  --------+-----------+---------------------------------------------------
//  s_*     | in        | command[2:0], item_key[31:0], item_tag[15:0], pad
//  m_*     | out       | found, out_key[31:0], out_tag[15:0],
//          |           | entry_count[4:0], overflow, pad
//
// each command is handled in order: the word is registered, then the
// slot shift register compares every slot in parallel and shifts
// a command word is taken while an earlier result still waits in the
// output register; execution waits only if that register is still full
// rst is synchronous: queue empty, no result pending; slot contents are
// not cleared and are never read before being written
// every command gives exactly one result word
//
module sorted_size_priority_queue (
  input  logic                        clk,
  input  logic                        rst,
  // slave side
  input  logic                        s_tvalid,
  output logic                        s_tready,
  input  logic [sspq_pkg::IN_W-1:0]   s_tdata,   // command, item_key, item_tag
  // master side
  output logic                        m_tvalid,
  input  logic                        m_tready,
  output logic [sspq_pkg::OUT_W-1:0]  m_tdata    // found, out_key, out_tag,
                                                 // entry_count, overflow
);
  import sspq_pkg::*;

  dp_ctrl_t ctrl;   // capture and execute strobes

  sspq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .ctrl     (ctrl)
  );

  // slots, count and result register
  sspq_datapath u_datapath (
    .clk    (clk),
    .rst    (rst),
    .ctrl   (ctrl),
    .s_data (s_tdata),
    .m_data (m_tdata)
  );

endmodule

### sim/tb_sorted_size_priority_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sorted_size_priority_queue
// self-checking bench for the sorted size priority queue: a shadow copy of
// the sorted slots predicts every result word, which is compared field by
// field as the block delivers it, under four idle/stall regimes
// ----------------------------------------------------------------------------
module tb_sorted_size_priority_queue;
  import sspq_pkg::*;

  localparam int CLK_HALF     = 6;
  localparam int PHASE_ITEMS  = 480;
  localparam int TAIL_CYCLES  = 20;        // block takes no new word while it executes one
  localparam int CYCLE_LIMIT  = 200000;

  // command codes the block does not decode, treated as no operation
  localparam logic [CMD_W-1:0] CMD_SPARE_LO = 3'd5;
  localparam logic [CMD_W-1:0] CMD_SPARE_HI = 3'd7;

  localparam logic [KEY_W-1:0] KEY_MAX = '1;
  localparam logic [TAG_W-1:0] TAG_MAX = '1;

  typedef struct {
    logic [CMD_W-1:0] cmd;
    logic [KEY_W-1:0] key;
    logic [TAG_W-1:0] tag;
  } queue_cmd_t;

  typedef struct {
    logic             found;
    logic [KEY_W-1:0] key;
    logic [TAG_W-1:0] tag;
    logic [CNT_W-1:0] count;
    logic             overflow;
  } queue_result_t;

  logic            clk      = 1'b0;
  logic            rst      = 1'b1;
  logic            s_tvalid = 1'b0;
  logic            s_tready;
  logic [IN_W-1:0] s_tdata  = '0;
  logic             m_tvalid;
  logic             m_tready = 1'b0;
  logic [OUT_W-1:0] m_tdata;

  sorted_size_priority_queue u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always #CLK_HALF clk = ~clk;

  // commands waiting to be sent, and result words waiting to arrive
  queue_cmd_t    cmd_backlog[$];
  queue_result_t expected_results[$];

  // idle and stall percentages for the current phase
  int src_idle_pct   = 0;
  int sink_stall_pct = 0;

  int fail_count  = 0;
  int n_words_in  = 0;
  int n_words_out = 0;
  int cycle_count = 0;

  // coverage tallies for the summary
  int n_insert    = 0;
  int n_dropped   = 0;
  int n_pop_hit   = 0;
  int n_pop_miss  = 0;
  int n_clear     = 0;
  int n_spare     = 0;
  int peak_held   = 0;

  // shadow of the sorted slots, slot 0 holds the largest key
  logic [KEY_W-1:0] shadow_key[DEPTH];
  logic [TAG_W-1:0] shadow_tag[DEPTH];
  int               shadow_held = 0;

  // apply one command to the shadow queue and log the word it must produce
  function void queue_apply(input logic [CMD_W-1:0] cmd, input logic [KEY_W-1:0] key,
                            input logic [TAG_W-1:0] tag);
    queue_result_t r;
    int            pos;
    r = '{found: 1'b0, key: '0, tag: '0, count: '0, overflow: 1'b0};
    case (cmd)
      CMD_INSERT: begin
        n_insert++;
        if (shadow_held >= DEPTH) begin
          r.overflow = 1'b1;
          n_dropped++;
        end else begin
          // first slot with a strictly smaller key; equal keys stay ahead
          pos = shadow_held;
          for (int i = shadow_held - 1; i >= 0; i--)
            if (shadow_key[i] < key) pos = i;
          for (int i = shadow_held; i > pos; i--) begin
            shadow_key[i] = shadow_key[i-1];
            shadow_tag[i] = shadow_tag[i-1];
          end
          shadow_key[pos] = key;
          shadow_tag[pos] = tag;
          shadow_held++;
          if (shadow_held > peak_held) peak_held = shadow_held;
        end
      end
      CMD_POP_FIRST, CMD_POP_SECOND: begin
        pos = (cmd == CMD_POP_FIRST) ? 0 : 1;
        if (shadow_held > pos) begin
          r.found = 1'b1;
          r.key   = shadow_key[pos];
          r.tag   = shadow_tag[pos];
          for (int i = pos; i + 1 < shadow_held; i++) begin
            shadow_key[i] = shadow_key[i+1];
            shadow_tag[i] = shadow_tag[i+1];
          end
          shadow_held--;
          n_pop_hit++;
        end else begin
          n_pop_miss++;
        end
      end
      CMD_CLEAR: begin
        shadow_held = 0;
        n_clear++;
      end
      CMD_COUNT: ;
      default: n_spare++;
    endcase
    r.count = shadow_held[CNT_W-1:0];
    expected_results.push_back(r);
  endfunction

  task report_mismatch(input string what, input logic [63:0] want, input logic [63:0] got);
    fail_count++;
    $display("mismatch at result word %0d, %s: expected %0h, got %0h",
             n_words_out, what, want, got);
  endtask

  // ---------------------------------------------------------------------------
  // stimulus building
  // ---------------------------------------------------------------------------
  task push_cmd(input logic [CMD_W-1:0] cmd, input logic [KEY_W-1:0] key,
                input logic [TAG_W-1:0] tag);
    queue_cmd_t c;
    c.cmd = cmd;
    c.key = key;
    c.tag = tag;
    cmd_backlog.push_back(c);
  endtask

  // keys are often drawn from a tiny range so that equal keys are common
  function logic [KEY_W-1:0] pick_key();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel < 4) return KEY_W'($urandom_range(0, 7));
    if (sel == 4) return $urandom_range(0, 1) ? KEY_MAX : '0;
    return KEY_W'($urandom);
  endfunction

  function logic [CMD_W-1:0] pick_cmd();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 45) return CMD_INSERT;
    if (sel < 65) return CMD_POP_FIRST;
    if (sel < 82) return CMD_POP_SECOND;
    if (sel < 90) return CMD_COUNT;
    if (sel < 94) return CMD_CLEAR;
    return CMD_W'($urandom_range(CMD_SPARE_LO, CMD_SPARE_HI));
  endfunction

  // one random episode of commands with random content
  task add_episode();
    int kind;
    kind = $urandom_range(0, 9);
    if (kind < 2) begin
      // fill to full, or up to four past it to take the overflow path, then pull some back
      push_cmd(CMD_CLEAR, pick_key(), TAG_W'($urandom));
      repeat (DEPTH + $urandom_range(0, 4))
        push_cmd(CMD_INSERT, pick_key(), TAG_W'($urandom));
      repeat ($urandom_range(2, 10))
        push_cmd($urandom_range(0, 1) ? CMD_POP_FIRST : CMD_POP_SECOND,
                 pick_key(), TAG_W'($urandom));
    end else if (kind == 2) begin
      // drain towards empty, running pops into an empty or single entry queue
      repeat (DEPTH / 2 + $urandom_range(0, DEPTH))
        push_cmd($urandom_range(0, 2) ? CMD_POP_FIRST : CMD_POP_SECOND,
                 pick_key(), TAG_W'($urandom));
      push_cmd(CMD_COUNT, pick_key(), TAG_W'($urandom));
    end else if (kind == 3) begin
      // noise over the whole command field
      repeat (3) push_cmd(CMD_W'($urandom_range(0, 7)), KEY_W'($urandom), TAG_W'($urandom));
    end else begin
      repeat (8) push_cmd(pick_cmd(), pick_key(), TAG_W'($urandom));
    end
  endtask

  // directed opening: extremes, every command, empty and near empty pops,
  // equal keys in arrival order, undecoded commands, clear
  task add_directed();
    push_cmd(CMD_INSERT, KEY_MAX, TAG_MAX);
    push_cmd(CMD_INSERT, '0, '0);
    push_cmd(CMD_INSERT, KEY_W'(7), TAG_W'(16'h0001));
    push_cmd(CMD_INSERT, KEY_W'(7), TAG_W'(16'h0002));
    push_cmd(CMD_COUNT, KEY_MAX, TAG_MAX);
    push_cmd(CMD_POP_SECOND, '0, '0);
    push_cmd(CMD_POP_FIRST, '0, '0);
    push_cmd(CMD_POP_FIRST, '0, '0);
    push_cmd(CMD_POP_SECOND, '0, '0);    // single entry left, nothing found
    push_cmd(CMD_POP_FIRST, '0, '0);
    push_cmd(CMD_POP_FIRST, '0, '0);     // empty queue
    push_cmd(CMD_POP_SECOND, '0, '0);    // empty queue
    for (int c = CMD_SPARE_LO; c <= CMD_SPARE_HI; c++)
      push_cmd(CMD_W'(c), KEY_W'($urandom), TAG_W'($urandom));
    push_cmd(CMD_INSERT, KEY_W'($urandom), TAG_W'($urandom));
    push_cmd(CMD_INSERT, KEY_MAX, '0);
    push_cmd(CMD_CLEAR, KEY_MAX, TAG_MAX);
    push_cmd(CMD_COUNT, '0, '0);
    push_cmd(CMD_POP_FIRST, '0, '0);     // nothing left after clear
  endtask

  // ---------------------------------------------------------------------------
  // driver: presents commands and drives the receiver's ready
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : drive
    queue_cmd_t      nxt;
    logic [IN_W-1:0] w;
    if (rst) begin
      s_tvalid <= 1'b0;
      m_tready <= 1'b0;
    end else begin
      // a new word may be loaded once the previous one has been taken
      if (!s_tvalid || s_tready) begin
        if (cmd_backlog.size() > 0 && $urandom_range(0, 99) >= src_idle_pct) begin
          nxt = cmd_backlog[0];
          cmd_backlog.delete(0);
          w = '0;
          w[IN_CMD_LO +: CMD_W] = nxt.cmd;
          w[IN_KEY_LO +: KEY_W] = nxt.key;
          w[IN_TAG_LO +: TAG_W] = nxt.tag;
          s_tvalid <= 1'b1;
          s_tdata  <= w;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
      m_tready <= ($urandom_range(0, 99) >= sink_stall_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: predicts on every accepted command, checks every result word
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : watch
    queue_result_t want;
    queue_result_t got;
    if (!rst) begin
      if (s_tvalid && s_tready) begin
        queue_apply(s_tdata[IN_CMD_LO +: CMD_W], s_tdata[IN_KEY_LO +: KEY_W],
                    s_tdata[IN_TAG_LO +: TAG_W]);
        n_words_in++;
      end
      if (m_tvalid && m_tready) begin
        // result word: found, out_key, out_tag, entry_count, overflow
        got.found    = m_tdata[0];
        got.key      = m_tdata[1 +: KEY_W];
        got.tag      = m_tdata[1 + KEY_W +: TAG_W];
        got.count    = m_tdata[1 + KEY_W + TAG_W +: CNT_W];
        got.overflow = m_tdata[OUT_USED - 1];
        if (expected_results.size() == 0) begin
          report_mismatch("word with nothing expected", '0, 64'(m_tdata));
        end else begin
          want = expected_results[0];
          expected_results.delete(0);
          if (got.found !== want.found)
            report_mismatch("found", 64'(want.found), 64'(got.found));
          if (got.key !== want.key)
            report_mismatch("out_key", 64'(want.key), 64'(got.key));
          if (got.tag !== want.tag)
            report_mismatch("out_tag", 64'(want.tag), 64'(got.tag));
          if (got.count !== want.count)
            report_mismatch("entry_count", 64'(want.count), 64'(got.count));
          if (got.overflow !== want.overflow)
            report_mismatch("overflow", 64'(want.overflow), 64'(got.overflow));
        end
        n_words_out++;
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d words still expected",
               cycle_count, expected_results.size());
      $display("FAIL sorted_size_priority_queue");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // sequencing: reset, then four phases, each drained before the next
  // ---------------------------------------------------------------------------
  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    for (int phase = 0; phase < 4; phase++) begin
      @(negedge clk);
      case (phase)
        0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
        1: begin src_idle_pct = 48; sink_stall_pct = 0;  end
        2: begin src_idle_pct = 0;  sink_stall_pct = 48; end
        default: begin src_idle_pct = 7; sink_stall_pct = 7; end
      endcase
      if (phase == 0) add_directed();
      while (cmd_backlog.size() < PHASE_ITEMS) add_episode();
      // wait until every command has been sent and every outstanding result has come back
      do @(negedge clk);
      while (cmd_backlog.size() != 0 || s_tvalid || expected_results.size() != 0);
    end
    repeat (TAIL_CYCLES) @(posedge clk);
    if (expected_results.size() != 0)
      report_mismatch("result words never delivered", '0, 64'(expected_results.size()));
    $display("%0d commands sent, %0d result words checked, %0d mismatches",
             n_words_in, n_words_out, fail_count);
    $display("inserts %0d (dropped when full %0d), pops found %0d, pops missed %0d, clears %0d,",
             n_insert, n_dropped, n_pop_hit, n_pop_miss, n_clear);
    $display("undecoded commands %0d, deepest occupancy %0d of %0d",
             n_spare, peak_held, DEPTH);
    if (fail_count == 0)
      $display("PASS sorted_size_priority_queue");
    else
      $display("FAIL sorted_size_priority_queue");
    $finish;
  end

endmodule

### sim.f
hdl/sspq_pkg.sv
hdl/sspq_datapath.sv
hdl/sspq_ctrl.sv
hdl/sorted_size_priority_queue.sv
sim/tb_sorted_size_priority_queue.sv
